// ----- rtl/core/q2s_pkg.sv -----
// Shared types, codes and constants for the two-stack queue.
package q2s_pkg;

  localparam int unsigned DepthDef = 8;
  localparam int unsigned DataW = 32;

  typedef enum logic {
    KindEnqueue = 1'b0,
    KindDequeue = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StOverflow  = 2'd1,
    StUnderflow = 2'd2
  } status_e;

  typedef struct packed {
    logic                    kind;
    logic signed [DataW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] result_value;
  } out_word_t;

  // Address width of a store with the given number of entries.
  function automatic int unsigned addr_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  // Width of a count that runs from zero up to the given depth.
  function automatic int unsigned cnt_w(input int unsigned depth);
    return $clog2(depth + 1);
  endfunction

endpackage

// ----- rtl/core/q2s_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module q2s_ram #(
  parameter int unsigned WIDTH = q2s_pkg::DataW,
  parameter int unsigned DEPTH = q2s_pkg::DepthDef
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [q2s_pkg::addr_w(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic                                re_i,
  input  logic [q2s_pkg::addr_w(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/queue_from_two_stacks_core.sv -----
// Top level: FIFO queue kept in an insertion stack and a deletion stack in two RAMs.
// An accepted word reaches the output register through StDone for an enqueue or an underflow,
// through StPop, StPopWait and StDone for a dequeue from a non-empty deletion stack, and first
// through StXfer for one that refills it, moving the insertion-stack fill one entry per cycle
// through the RAM read port. The next word is taken once back in StIdle, later while the
// output word is stalled. Reset empties both stacks at once; RAM contents are kept.
module queue_from_two_stacks_core #(
  parameter int unsigned DEPTH = q2s_pkg::DepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  q2s_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output q2s_pkg::out_word_t out_word_o
);

  localparam int unsigned AW = q2s_pkg::addr_w(DEPTH);
  localparam int unsigned CntW = q2s_pkg::cnt_w(DEPTH);

  typedef enum logic [2:0] {
    StIdle,
    StXfer,
    StPop,
    StPopWait,
    StDone
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    ins_cnt_q, ins_cnt_d;
  logic [CntW-1:0]    del_cnt_q, del_cnt_d;
  logic               pend_q, pend_d;
  q2s_pkg::out_word_t res_q, res_d;
  logic               out_valid_q, out_valid_d;
  q2s_pkg::out_word_t out_word_q, out_word_d;

  logic [CntW-1:0]    ins_top, del_top;

  logic                       ins_we, ins_re;
  logic [AW-1:0]              ins_waddr, ins_raddr;
  logic [q2s_pkg::DataW-1:0]  ins_rdata;
  logic                       del_we, del_re;
  logic [AW-1:0]              del_waddr, del_raddr;
  logic [q2s_pkg::DataW-1:0]  del_wdata, del_rdata;

  assign ins_top = ins_cnt_q - CntW'(1);
  assign del_top = del_cnt_q - CntW'(1);

  q2s_ram #(
    .WIDTH(q2s_pkg::DataW),
    .DEPTH(DEPTH)
  ) u_ins_ram (
    .clk_i  (clk_i),
    .we_i   (ins_we),
    .waddr_i(ins_waddr),
    .wdata_i(in_word_i.value),
    .re_i   (ins_re),
    .raddr_i(ins_raddr),
    .rdata_o(ins_rdata)
  );

  q2s_ram #(
    .WIDTH(q2s_pkg::DataW),
    .DEPTH(DEPTH)
  ) u_del_ram (
    .clk_i  (clk_i),
    .we_i   (del_we),
    .waddr_i(del_waddr),
    .wdata_i(del_wdata),
    .re_i   (del_re),
    .raddr_i(del_raddr),
    .rdata_o(del_rdata)
  );

  always_comb begin
    state_d     = state_q;
    ins_cnt_d   = ins_cnt_q;
    del_cnt_d   = del_cnt_q;
    pend_d      = pend_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    ins_we      = 1'b0;
    ins_waddr   = ins_cnt_q[AW-1:0];
    ins_re      = 1'b0;
    ins_raddr   = ins_top[AW-1:0];
    del_we      = 1'b0;
    del_waddr   = del_cnt_q[AW-1:0];
    del_wdata   = ins_rdata;
    del_re      = 1'b0;
    del_raddr   = del_top[AW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          res_d.status       = q2s_pkg::StOk;
          res_d.result_value = '0;
          state_d            = StDone;
          if (in_word_i.kind == q2s_pkg::KindEnqueue) begin
            if (ins_cnt_q == CntW'(DEPTH)) begin
              res_d.status = q2s_pkg::StOverflow;
            end else begin
              ins_we    = 1'b1;
              ins_cnt_d = ins_cnt_q + CntW'(1);
            end
          end else if (ins_cnt_q == '0 && del_cnt_q == '0) begin
            res_d.status = q2s_pkg::StUnderflow;
          end else if (del_cnt_q == '0) begin
            pend_d  = 1'b0;
            state_d = StXfer;
          end else begin
            state_d = StPop;
          end
        end
      end
      StXfer: begin
        // Reads of the insertion stack are pipelined with writes of the
        // word read in the previous cycle onto the deletion stack.
        if (pend_q) begin
          del_we    = 1'b1;
          del_cnt_d = del_cnt_q + CntW'(1);
        end
        if (ins_cnt_q != '0) begin
          ins_re    = 1'b1;
          ins_cnt_d = ins_top;
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = StPop;
        end
      end
      StPop: begin
        del_re    = 1'b1;
        del_cnt_d = del_top;
        state_d   = StPopWait;
      end
      StPopWait: begin
        res_d.status       = q2s_pkg::StOk;
        res_d.result_value = del_rdata;
        state_d            = StDone;
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_word_d  = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ins_cnt_q   <= '0;
      del_cnt_q   <= '0;
      pend_q      <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      state_q     <= state_d;
      ins_cnt_q   <= ins_cnt_d;
      del_cnt_q   <= del_cnt_d;
      pend_q      <= pend_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  logic [CntW:0] fill_sum;
  assign fill_sum = {1'b0, ins_cnt_q} + {1'b0, del_cnt_q} + {{CntW{1'b0}}, pend_q};

  a_ins_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_cnt_q <= CntW'(DEPTH))
    else $error("insertion count exceeds depth");

  a_del_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    del_cnt_q <= CntW'(DEPTH))
    else $error("deletion count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StPop |-> del_cnt_q != '0)
    else $error("pop from an empty deletion stack");

  a_xfer_conserves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StXfer && $past(state_q) == StXfer) |-> fill_sum == $past(fill_sum))
    else $error("transfer lost or duplicated an entry");

  a_xfer_entry_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && in_valid_i && state_d == StXfer) |=> del_cnt_q == '0 && !pend_q)
    else $error("transfer started with a non-empty deletion stack");

endmodule
